>>> src/assert_macros.svh
// Assertion macros for the RTL.
// KFC_ASSERT checks that a property holds; KFC_DENY checks that a condition never holds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define KFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KFC_DENY(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define KFC_ASSERT(label, clk, rst, prop, msg)
`define KFC_DENY(label, clk, rst, cond, msg)
`endif
`endif

>>> src/kfc_pkg.sv
package kfc_pkg;

   localparam int WORD_W = 32;

   // key kinds
   typedef enum logic [1:0] {
      KIND_DIGIT = 2'd0,
      KIND_OPER  = 2'd1,
      KIND_BACK  = 2'd2,
      KIND_CLEAR = 2'd3
   } key_kind_type;

   // operator codes; codes five to seven are stored but act as no-ops
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_EQ  = 3'd4;

   localparam logic [WORD_W-1:0] RADIX = 32'd10;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_MUL   = 2'd1,
      ST_DIV   = 2'd2,
      ST_WRITE = 2'd3
   } state_type;

endpackage

>>> src/keypad_four_function_calculator_top.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  req_type, req_key_digit, req_key_op
// rsp       rsp_valid / rsp_stall  rsp_display_value, rsp_divide_by_zero
//
// Digit, add, subtract, equal, clear, unused operator codes, divide by zero and backspace
// of a zero entry pass from idle to the write state, then back to idle once the output is free.
// Multiply, divide and backspace of a nonzero entry run 32 steps of the shared shift/add-subtract
// unit before the write state; one item at a time, since new input stalls until idle.
// Synchronous reset clears the sequencer, accumulator, entry and pending operation (add).
// A stalled result holds in the output register; a finished item waits in the write state until it is free.
`include "assert_macros.svh"

module keypad_four_function_calculator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_key_digit,
   input  logic [2:0]  req_key_op,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_display_value,
   output logic        rsp_divide_by_zero
);
   import kfc_pkg::*;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] entry_ff, entry_in;
   logic [2:0]        pending_ff, pending_in;
   logic [WORD_W-1:0] work_a_ff, work_a_in;
   logic [WORD_W-1:0] work_b_ff, work_b_in;
   logic [WORD_W-1:0] work_q_ff, work_q_in;
   logic [4:0]        count_ff, count_in;
   logic              neg_ff, neg_in;
   logic              tgt_acc_ff, tgt_acc_in;
   logic [WORD_W-1:0] res_ff, res_in;
   logic              dz_ff, dz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_dz_ff, rsp_dz_in;

   logic [WORD_W-1:0] add_a, add_b;
   logic              add_inv;
   logic [WORD_W:0]   sum;
   logic              ge;
   logic [WORD_W-1:0] quot, quot_signed;
   logic              accept;
   logic              out_free;
   key_kind_type      kind;

   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
      magnitude = v[WORD_W-1] ? (~v + 1'b1) : v;
   endfunction

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign kind     = key_kind_type'(req_type);

   // shared adder: add/subtract in idle, shift-add in multiply, trial subtract in divide
   always_comb begin
      add_a   = acc_ff;
      add_b   = entry_ff;
      add_inv = (pending_ff == OP_SUB);
      case (state_ff)
         ST_MUL: begin
            add_a   = {work_a_ff[WORD_W-2:0], 1'b0};
            add_b   = work_q_ff[WORD_W-1] ? work_b_ff : '0;
            add_inv = 1'b0;
         end
         ST_DIV: begin
            add_a   = {work_a_ff[WORD_W-2:0], work_q_ff[WORD_W-1]};
            add_b   = work_b_ff;
            add_inv = 1'b1;
         end
         default: ;
      endcase
      sum = {1'b0, add_a} + {1'b0, add_b ^ {WORD_W{add_inv}}} + {{WORD_W{1'b0}}, add_inv};
   end

   assign ge          = sum[WORD_W];
   assign quot        = {work_q_ff[WORD_W-2:0], ge};
   assign quot_signed = neg_ff ? (~quot + 1'b1) : quot;

   // sequencer: next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      entry_in     = entry_ff;
      pending_in   = pending_ff;
      work_a_in    = work_a_ff;
      work_b_in    = work_b_ff;
      work_q_in    = work_q_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      tgt_acc_in   = tgt_acc_ff;
      res_in       = res_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dz_in    = 1'b0;
               state_in = ST_WRITE;
               count_in = 5'd31;
               case (kind)
                  KIND_DIGIT: begin
                     entry_in = {entry_ff[WORD_W-4:0], 3'b000} + {entry_ff[WORD_W-2:0], 1'b0}
                                + {{(WORD_W-4){1'b0}}, req_key_digit};
                     res_in   = entry_in;
                  end
                  KIND_OPER: begin
                     pending_in = req_key_op;
                     entry_in   = '0;
                     res_in     = acc_ff;
                     case (pending_ff)
                        OP_ADD, OP_SUB: begin
                           acc_in = sum[WORD_W-1:0];
                           res_in = sum[WORD_W-1:0];
                        end
                        OP_MUL: begin
                           work_a_in = '0;
                           work_b_in = acc_ff;
                           work_q_in = entry_ff;
                           state_in  = ST_MUL;
                        end
                        OP_DIV: begin
                           if (entry_ff == '0) begin
                              dz_in = 1'b1;
                           end else begin
                              work_a_in  = '0;
                              work_b_in  = magnitude(entry_ff);
                              work_q_in  = magnitude(acc_ff);
                              neg_in     = acc_ff[WORD_W-1] ^ entry_ff[WORD_W-1];
                              tgt_acc_in = 1'b1;
                              state_in   = ST_DIV;
                           end
                        end
                        OP_EQ: begin
                           if (entry_ff != '0) begin
                              acc_in = entry_ff;
                              res_in = entry_ff;
                           end
                        end
                        default: ;
                     endcase
                  end
                  KIND_BACK: begin
                     res_in = entry_ff;
                     if (entry_ff != '0) begin
                        work_a_in  = '0;
                        work_b_in  = RADIX;
                        work_q_in  = magnitude(entry_ff);
                        neg_in     = entry_ff[WORD_W-1];
                        tgt_acc_in = 1'b0;
                        state_in   = ST_DIV;
                     end
                  end
                  KIND_CLEAR: begin
                     acc_in   = '0;
                     entry_in = '0;
                     res_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            // shift-add over multiplier bits, most significant first
            work_a_in = sum[WORD_W-1:0];
            work_q_in = {work_q_ff[WORD_W-2:0], 1'b0};
            count_in  = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               acc_in   = sum[WORD_W-1:0];
               res_in   = sum[WORD_W-1:0];
               state_in = ST_WRITE;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per step
            work_a_in = ge ? sum[WORD_W-1:0] : add_a;
            work_q_in = quot;
            count_in  = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               res_in = quot_signed;
               if (tgt_acc_ff) begin
                  acc_in = quot_signed;
               end else begin
                  entry_in = quot_signed;
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // release the result once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_dz_in    = dz_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // architectural and output control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         entry_ff     <= '0;
         pending_ff   <= OP_ADD;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         entry_ff     <= entry_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work and payload registers
   always_ff @(posedge clock) begin
      work_a_ff    <= work_a_in;
      work_b_ff    <= work_b_in;
      work_q_ff    <= work_q_in;
      count_ff     <= count_in;
      neg_ff       <= neg_in;
      tgt_acc_ff   <= tgt_acc_in;
      res_ff       <= res_in;
      dz_ff        <= dz_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_display_value  = rsp_value_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   `KFC_ASSERT(a_busy_after_transfer, clock, reset, accept |=> req_stall,
               "input taken while busy")
   `KFC_ASSERT(a_iter_continues, clock, reset,
               (state_ff == ST_MUL && count_ff != 5'd0) |=> (state_ff == ST_MUL),
               "multiply left early")
   `KFC_ASSERT(a_rsp_from_write, clock, reset,
               $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WRITE),
               "result raised outside write")
   `KFC_DENY(a_div_nonzero, clock, reset, (state_ff == ST_DIV && work_b_ff == '0),
             "divide with zero divisor")

endmodule

>>> sim/keypad_four_function_calculator_top_test.sv
`timescale 1ns / 1ps

module keypad_four_function_calculator_top_test;

   import kfc_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_KEYS  = 1200;
   localparam int HOLD_CYCLES  = 600;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      key_kind_type kind;
      logic [3:0]   digit;
      logic [2:0]   op;
   } key_press_type;

   typedef struct {
      logic signed [31:0] shown;
      logic               dz;
   } display_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = 2'd0;
   logic [3:0]         req_key_digit = 4'd0;
   logic [2:0]         req_key_op = 3'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_display_value;
   logic               rsp_divide_by_zero;

   // keys waiting to be offered, and displays waiting to come back
   key_press_type key_queue[$];
   display_type   display_expected[$];

   // calculator state as the predictor sees it
   logic [31:0] calc_acc = '0;
   logic [31:0] calc_entry = '0;
   logic [2:0]  calc_pending = OP_ADD;

   int mismatch_count = 0;
   int results_seen = 0;
   int quiet_cycles = 0;

   // sender burst/gap bookkeeping
   int            burst_left = 0;
   int            gap_left = 0;
   key_press_type next_key;

   // receiver stall pattern bookkeeping
   int stall_mode = 0;
   int run_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   keypad_four_function_calculator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_key_digit      (req_key_digit),
      .req_key_op         (req_key_op),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_display_value  (rsp_display_value),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #HALF_PERIOD clock = ~clock;

   // signed 32-bit division, quotient truncated toward zero
   function automatic logic [31:0] div_trunc(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] quo;
      mag_n = num[31] ? -num : num;
      mag_d = den[31] ? -den : den;
      quo = mag_n / mag_d;
      return (num[31] ^ den[31]) ? -quo : quo;
   endfunction

   // advance the calculator by one key and record the display it must show
   function automatic void apply_key(key_kind_type kind, logic [3:0] digit, logic [2:0] op);
      display_type res;
      res.dz = 1'b0;
      res.shown = '0;
      case (kind)
         KIND_DIGIT: begin
            calc_entry = calc_entry * RADIX + {28'd0, digit};
            res.shown = calc_entry;
         end
         KIND_OPER: begin
            case (calc_pending)
               OP_ADD: calc_acc = calc_acc + calc_entry;
               OP_SUB: calc_acc = calc_acc - calc_entry;
               OP_MUL: calc_acc = calc_acc * calc_entry;
               OP_DIV: begin
                  if (calc_entry == '0) res.dz = 1'b1;
                  else calc_acc = div_trunc(calc_acc, calc_entry);
               end
               OP_EQ: begin
                  if (calc_entry != '0) calc_acc = calc_entry;
               end
               default: ;
            endcase
            res.shown = calc_acc;
            calc_entry = '0;
            calc_pending = op;
         end
         KIND_BACK: begin
            if (calc_entry != '0) calc_entry = div_trunc(calc_entry, RADIX);
            res.shown = calc_entry;
         end
         default: begin
            calc_acc = '0;
            calc_entry = '0;
         end
      endcase
      display_expected.push_back(res);
   endfunction

   // queue one key; fields the key kind does not use get random values
   task automatic queue_key(key_kind_type kind, logic [3:0] digit, logic [2:0] op);
      key_press_type k;
      k.kind = kind;
      k.digit = (kind == KIND_DIGIT) ? digit : 4'($urandom_range(0, 15));
      k.op = (kind == KIND_OPER) ? op : 3'($urandom_range(0, 7));
      key_queue.push_back(k);
   endtask

   // type the decimal digits of an unsigned value, most significant first
   task automatic type_number(logic [31:0] value);
      logic [3:0] digits[$];
      do begin
         digits.push_front(4'(value % 10));
         value = value / 10;
      end while (value != 0);
      foreach (digits[i]) queue_key(KIND_DIGIT, digits[i], OP_ADD);
   endtask

   // sender: offer queued keys in bursts, hold the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || key_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            next_key = key_queue.pop_front();
            req_type <= next_key.kind;
            req_key_digit <= next_key.digit;
            req_key_op <= next_key.op;
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            end
         end
      end
   end

   // receiver: one long hold-off, otherwise runs of pass, solid stall or dither
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         run_left = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 400) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (run_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            run_left = (stall_mode == 0) ? $urandom_range(1, 120) : $urandom_range(1, 40);
         end
         run_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'b1;
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
      end
   end

   // check each result transfer first, then predict from each key transfer
   always @(posedge clock) begin
      display_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (display_expected.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("%0t: unexpected result display=%0d dz=%0b", $realtime,
                           rsp_display_value, rsp_divide_by_zero);
               mismatch_count++;
            end else begin
               want = display_expected.pop_front();
               if (rsp_display_value !== want.shown || rsp_divide_by_zero !== want.dz) begin
                  if (mismatch_count < REPORT_MAX)
                     $display("%0t: mismatch display exp=%0d act=%0d, dz exp=%0b act=%0b",
                              $realtime, want.shown, rsp_display_value, want.dz,
                              rsp_divide_by_zero);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            apply_key(key_kind_type'(req_type), req_key_digit, req_key_op);
      end
   end

   // watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int n_digits;

      // most negative accumulator, then divided by minus one
      type_number(32'd2147483648);
      queue_key(KIND_OPER, 4'd0, OP_DIV);
      // entry of minus eleven, backspace truncates it to minus one
      type_number(32'd4294967285);
      queue_key(KIND_BACK, 4'd0, OP_ADD);
      queue_key(KIND_OPER, 4'd0, 3'd7);
      // raw digit above nine, then an unused operator code applied
      queue_key(KIND_DIGIT, 4'd15, OP_ADD);
      queue_key(KIND_OPER, 4'd0, OP_DIV);
      // divide with an empty entry
      queue_key(KIND_OPER, 4'd0, OP_ADD);
      queue_key(KIND_DIGIT, 4'd9, OP_ADD);
      queue_key(KIND_OPER, 4'd0, OP_MUL);
      // clear keeps the pending multiply
      queue_key(KIND_CLEAR, 4'd0, OP_ADD);
      queue_key(KIND_DIGIT, 4'd5, OP_ADD);
      queue_key(KIND_OPER, 4'd0, OP_SUB);
      queue_key(KIND_DIGIT, 4'd2, OP_ADD);
      queue_key(KIND_DIGIT, 4'd0, OP_ADD);
      queue_key(KIND_OPER, 4'd0, 3'd5);

      // random part: mostly number-then-operator sequences, some noise keys
      while (key_queue.size() < 35 + RANDOM_KEYS) begin
         if ($urandom_range(0, 99) < 80) begin
            n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 11)
                                                   : $urandom_range(0, 3);
            repeat (n_digits) queue_key(KIND_DIGIT, 4'($urandom_range(0, 9)), OP_ADD);
            if ($urandom_range(0, 5) == 0) queue_key(KIND_BACK, 4'd0, OP_ADD);
            queue_key(KIND_OPER, 4'd0,
                      ($urandom_range(0, 5) == 0) ? OP_EQ : 3'($urandom_range(0, 4)));
         end else begin
            queue_key(key_kind_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      3'($urandom_range(0, 7)));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // wait for all keys to transfer and all displays to return, then drain
      while (key_queue.size() != 0 || req_valid || display_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && display_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
